### rtl/irn_pkg.sv
// Shared types, constants and symbol tables for the integer to Roman numeral block.
// Used by irn_ctrl, irn_datapath and int_to_roman_numeral_top.
package irn_pkg;

	localparam int VALUE_W  = 12;
	localparam int LETTER_W = 8;
	localparam int SYM_COUNT = 13;
	localparam int SYM_W    = $clog2(SYM_COUNT);

	localparam logic [LETTER_W-1:0] LTR_NONE = 8'h00;
	localparam logic [LETTER_W-1:0] LTR_I    = 8'h49;
	localparam logic [LETTER_W-1:0] LTR_V    = 8'h56;
	localparam logic [LETTER_W-1:0] LTR_X    = 8'h58;
	localparam logic [LETTER_W-1:0] LTR_L    = 8'h4C;
	localparam logic [LETTER_W-1:0] LTR_C    = 8'h43;
	localparam logic [LETTER_W-1:0] LTR_D    = 8'h44;
	localparam logic [LETTER_W-1:0] LTR_M    = 8'h4D;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
	} status_t;

	function automatic logic [VALUE_W-1:0] sym_weight(input logic [SYM_W-1:0] k);
		logic [VALUE_W-1:0] w;
		case (k)
			4'd0:    w = 12'd1000;
			4'd1:    w = 12'd900;
			4'd2:    w = 12'd500;
			4'd3:    w = 12'd400;
			4'd4:    w = 12'd100;
			4'd5:    w = 12'd90;
			4'd6:    w = 12'd50;
			4'd7:    w = 12'd40;
			4'd8:    w = 12'd10;
			4'd9:    w = 12'd9;
			4'd10:   w = 12'd5;
			4'd11:   w = 12'd4;
			default: w = 12'd1;
		endcase
		return w;
	endfunction

	function automatic logic [LETTER_W-1:0] sym_first(input logic [SYM_W-1:0] k);
		logic [LETTER_W-1:0] c;
		case (k)
			4'd0:    c = LTR_M;
			4'd1:    c = LTR_C;
			4'd2:    c = LTR_D;
			4'd3:    c = LTR_C;
			4'd4:    c = LTR_C;
			4'd5:    c = LTR_X;
			4'd6:    c = LTR_L;
			4'd7:    c = LTR_X;
			4'd8:    c = LTR_X;
			4'd9:    c = LTR_I;
			4'd10:   c = LTR_V;
			default: c = LTR_I;
		endcase
		return c;
	endfunction

	function automatic logic [LETTER_W-1:0] sym_second(input logic [SYM_W-1:0] k);
		logic [LETTER_W-1:0] c;
		case (k)
			4'd1:    c = LTR_M;
			4'd3:    c = LTR_D;
			4'd5:    c = LTR_C;
			4'd7:    c = LTR_L;
			4'd9:    c = LTR_X;
			4'd11:   c = LTR_V;
			default: c = LTR_NONE;
		endcase
		return c;
	endfunction

endpackage

### rtl/irn_ctrl.sv
// Controller state machine for the Roman numeral block.
// Depends on irn_pkg; drives irn_datapath through cmd_t and reads status_t.
module irn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  irn_pkg::status_t status,
	output irn_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             strobe
);
	import irn_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.empty || status.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load    = 1'b0;
		cmd.advance = 1'b0;
		busy        = 1'b0;
		strobe      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EMIT: begin
				busy        = 1'b1;
				strobe      = !status.empty;
				cmd.advance = !status.empty;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### rtl/irn_datapath.sv
// Datapath for the Roman numeral block: remaining value, symbol select, letter output.
// Depends on irn_pkg symbol tables; commanded by irn_ctrl.
module irn_datapath (
	input  logic                           clk,
	input  logic [irn_pkg::VALUE_W-1:0]    value,
	input  irn_pkg::cmd_t                  cmd,
	output irn_pkg::status_t               status,
	output logic [irn_pkg::LETTER_W-1:0]   letter
);
	import irn_pkg::*;

	logic [VALUE_W-1:0] rest_q;
	logic [SYM_W-1:0]   sym_q;
	logic               half_q;
	logic [SYM_W-1:0]   sel;
	logic [VALUE_W-1:0] rest_next;
	logic               two_letter;

	always_comb begin
		sel = SYM_W'(SYM_COUNT - 1);
		for (int k = SYM_COUNT - 1; k >= 0; k--) begin
			if (sym_weight(SYM_W'(k)) <= rest_q) sel = SYM_W'(k);
		end
	end

	assign rest_next  = rest_q - sym_weight(sel);
	assign two_letter = sym_second(sel) != LTR_NONE;

	always_comb begin
		status.empty = (rest_q == '0) && !half_q;
		if (half_q) begin
			letter      = sym_second(sym_q);
			status.last = rest_q == '0;
		end else begin
			letter      = sym_first(sel);
			status.last = !two_letter && (rest_next == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
			half_q <= 1'b0;
			sym_q  <= '0;
		end else if (cmd.advance) begin
			if (half_q) begin
				half_q <= 1'b0;
			end else begin
				rest_q <= rest_next;
				sym_q  <= sel;
				half_q <= two_letter;
			end
		end
	end

endmodule

### rtl/int_to_roman_numeral_top.sv
// Integer to Roman numeral converter, top level.
// Instantiates irn_ctrl and irn_datapath; depends on irn_pkg.
//
// Usage:
//   Raise start with value while busy is low; the transaction is taken at that
//   clock edge and busy rises in the next cycle.
//   The numeral leaves one ASCII letter per cycle on letter, marked by strobe,
//   with last high on its final letter. Letters of one numeral come in
//   consecutive cycles, starting the cycle after the transaction is taken.
//   Busy stays high while the letters of the numeral are emitted and falls after
//   the final letter; a new value is taken only while busy is low.
//   A value of zero gives no letters and holds busy for one cycle.
//   Values above 3999 yield a run of four M letters for the thousands.
//   The receiver cannot stall: every strobe is a delivered letter.
//   Reset (arst_n low) returns the controller to idle at once and drops any
//   numeral in progress; nothing is kept between transactions.
module int_to_roman_numeral_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [irn_pkg::VALUE_W-1:0]   value,
	output logic                          busy,
	output logic                          strobe,
	output logic [irn_pkg::LETTER_W-1:0]  letter,
	output logic                          last
);
	import irn_pkg::*;

	cmd_t    cmd;
	status_t status;

	irn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	irn_datapath u_datapath (
		.clk    (clk),
		.value  (value),
		.cmd    (cmd),
		.status (status),
		.letter (letter)
	);

	assign last = strobe && status.last;

`ifndef SYNTH
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("letter strobed while not busy");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy)
		else $error("busy held after last letter");

	a_letters_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a numeral");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");
`endif

endmodule
